// ----- design/postfix_predicate_evaluator_macros.svh -----
// Assertion macros shared by the postfix predicate evaluator RTL
`ifndef POSTFIX_PREDICATE_EVALUATOR_MACROS_SVH
`define POSTFIX_PREDICATE_EVALUATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock, off during reset
`define PPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define PPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define PPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/ppe_pkg.sv -----
// Types, codes and sizes of the postfix predicate evaluator
package ppe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(DATA_W);

    typedef enum logic [1:0] {
        KIND_OPERAND = 2'd0,
        KIND_NEGATE  = 2'd1,
        KIND_BINARY  = 2'd2,
        KIND_IGNORE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_AND  = 3'd0,
        OP_OR   = 3'd1,
        OP_GT   = 3'd2,
        OP_LT   = 3'd3,
        OP_MOD  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_UNDER    = 3'd1,
        ERR_OVER     = 3'd2,
        ERR_DIVZERO  = 3'd3,
        ERR_LEFTOVER = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_WB
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic cap;      // latch token beat, read top two entries
        logic upd;      // commit stack update
        logic div_go;   // launch remainder unit
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div; // modulo with two operands and nonzero divisor
        logic div_done;
        logic last;
    } t_stat;

endpackage

// ----- design/ppe_if.sv -----
// Token and result channel interfaces
interface ppe_tok_if;
    import ppe_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [2:0]        operation;
    logic signed [DATA_W-1:0] value;
    logic              last;

    modport source (output valid, kind, operation, value, last, input ready);
    modport sink   (input valid, kind, operation, value, last, output ready);
endinterface

interface ppe_res_if;
    import ppe_pkg::*;

    logic              valid;
    logic              ready;
    logic signed [DATA_W-1:0] answer;
    logic [2:0]        error;

    modport source (output valid, answer, error, input ready);
    modport sink   (input valid, answer, error, output ready);
endinterface

// ----- design/postfix_predicate_evaluator.sv -----
// Top level of the postfix predicate evaluator
//
//  channel  dir  handshake      payload
//  i_tok    in   valid/ready    kind[1:0], operation[2:0], value[31:0] signed, last
//  o_res    out  valid/ready    answer[31:0] signed, error[2:0]
//
// A token is accepted and its top two stack entries are read in ST_IDLE; the stack
// is updated in ST_EXEC. A modulo with a nonzero divisor launches the remainder unit
// (one bit per cycle, 32 steps) from ST_EXEC, waits in ST_DIV and updates in ST_WB.
// Reset clears the stack depth, the error code and the result valid; no clearing pass.
// The result sits in an output register; a last token stalls only while the
// previous result has not been taken.
`include "postfix_predicate_evaluator_macros.svh"

module postfix_predicate_evaluator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppe_tok_if.sink   i_tok,
    ppe_res_if.source o_res
);
    import ppe_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  w_res_held;

    ppe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_tok.valid),
        .o_in_ready  (i_tok.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ppe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_tok.kind),
        .i_operation (i_tok.operation),
        .i_value     (i_tok.value),
        .i_last      (i_tok.last),
        .o_stat      (stat),
        .o_answer    (o_res.answer),
        .o_error     (o_res.error)
    );

    // Result beat offered but not taken this cycle
    assign w_res_held = o_res.valid && !o_res.ready;

    // Never overwrite a result that is still waiting
    `PPE_ASSERT_IMP(a_no_result_overwrite, i_clk, i_rst_n, cmd.upd && stat.last, !w_res_held)
    // One token in flight: no accept right after an accept
    `PPE_ASSERT_NXT(a_one_token, i_clk, i_rst_n, i_tok.valid && i_tok.ready, !i_tok.ready)
    // A launched modulo does not commit before the remainder is ready
    `PPE_ASSERT_NXT(a_div_holds_commit, i_clk, i_rst_n, cmd.div_go, !cmd.upd)

endmodule

// ----- design/ppe_div.sv -----
// Iterative restoring remainder unit, one quotient bit per cycle
module ppe_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [ppe_pkg::DATA_W-1:0] i_dividend,
    input  logic signed [ppe_pkg::DATA_W-1:0] i_divisor,
    output logic                          o_done,
    output logic signed [ppe_pkg::DATA_W-1:0] o_rem
);
    import ppe_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_dvd;
    logic [DATA_W-1:0] r_dsr;
    logic [DATA_W-1:0] r_rem;
    logic              r_neg;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] n_rem;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_shift = {r_rem, r_dvd[DATA_W-1]};
        w_diff  = w_shift - {1'b0, r_dsr};
        if (w_shift >= {1'b0, r_dsr}) begin
            n_rem = w_diff[DATA_W-1:0];
        end else begin
            n_rem = w_shift[DATA_W-1:0];
        end
    end

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    // Operand magnitudes and running remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend[DATA_W-1] ? DATA_W'(-i_dividend) : DATA_W'(i_dividend);
            r_dsr <= i_divisor[DATA_W-1]  ? DATA_W'(-i_divisor)  : DATA_W'(i_divisor);
            r_neg <= i_dividend[DATA_W-1];
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
        end
    end

    // Remainder takes the sign of the dividend
    assign o_rem  = r_neg ? $signed(-r_rem) : $signed(r_rem);
    assign o_done = r_done;

endmodule

// ----- design/ppe_dpath.sv -----
// Datapath: value stack memory, depth and error registers, operator logic
module ppe_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppe_pkg::t_cmd                 i_cmd,
    input  logic [1:0]                    i_kind,
    input  logic [2:0]                    i_operation,
    input  logic signed [ppe_pkg::DATA_W-1:0] i_value,
    input  logic                          i_last,
    output ppe_pkg::t_stat                o_stat,
    output logic signed [ppe_pkg::DATA_W-1:0] o_answer,
    output logic [2:0]                    o_error
);
    import ppe_pkg::*;

    logic signed [DATA_W-1:0] r_stack [STACK_DEPTH];

    t_kind                    r_kind;
    logic [2:0]               r_op;
    logic signed [DATA_W-1:0] r_value;
    logic                     r_last;
    logic [DEPTH_W-1:0]       r_depth;
    t_err                     r_err;
    logic signed [DATA_W-1:0] r_rd_top;
    logic signed [DATA_W-1:0] r_rd_nos;
    logic signed [DATA_W-1:0] r_answer;
    logic [2:0]               r_error;

    logic [DEPTH_W-1:0]       n_depth;
    t_err                     n_err;
    logic                     w_ge1;
    logic                     w_ge2;
    logic                     w_full;
    logic                     w_we;
    logic [ADDR_W-1:0]        w_waddr;
    logic signed [DATA_W-1:0] w_wdata;
    logic signed [DATA_W-1:0] w_alu;
    logic                     w_flag;
    t_err                     w_flag_code;
    logic signed [DATA_W-1:0] w_answer;
    t_err                     w_error;
    logic                     w_div_done;
    logic signed [DATA_W-1:0] w_div_rem;
    logic [ADDR_W-1:0]        w_rd_a;
    logic [ADDR_W-1:0]        w_rd_b;

    ppe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (r_rd_nos),
        .i_divisor  (r_rd_top),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    assign w_ge1  = (r_depth != '0);
    assign w_ge2  = (r_depth >= DEPTH_W'(2));
    assign w_full = (r_depth == DEPTH_W'(STACK_DEPTH));
    assign w_rd_a = ADDR_W'(r_depth - DEPTH_W'(1));
    assign w_rd_b = ADDR_W'(r_depth - DEPTH_W'(2));

    // Binary operator on next-of-top (left) and top (right)
    always_comb begin
        case (r_op)
            OP_AND:  w_alu = DATA_W'((r_rd_nos != '0) && (r_rd_top != '0));
            OP_OR:   w_alu = DATA_W'((r_rd_nos != '0) || (r_rd_top != '0));
            OP_GT:   w_alu = DATA_W'(r_rd_nos > r_rd_top);
            OP_LT:   w_alu = DATA_W'(r_rd_nos < r_rd_top);
            OP_MOD:  w_alu = (r_rd_top == '0) ? '0 : w_div_rem;
            default: w_alu = '0;
        endcase
    end

    // Stack update for the held token
    always_comb begin
        n_depth     = r_depth;
        w_we        = 1'b0;
        w_waddr     = r_depth[ADDR_W-1:0];
        w_wdata     = r_value;
        w_flag      = 1'b0;
        w_flag_code = ERR_OK;
        case (r_kind)
            KIND_OPERAND: begin
                if (w_full) begin
                    w_flag      = 1'b1;
                    w_flag_code = ERR_OVER;
                end else begin
                    w_we    = 1'b1;
                    n_depth = r_depth + DEPTH_W'(1);
                end
            end
            KIND_NEGATE: begin
                if (!w_ge1) begin
                    w_flag      = 1'b1;
                    w_flag_code = ERR_UNDER;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_rd_a;
                    w_wdata = DATA_W'(r_rd_top == '0);
                end
            end
            KIND_BINARY: begin
                if (!w_ge2) begin
                    w_flag      = 1'b1;
                    w_flag_code = ERR_UNDER;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_rd_b;
                    w_wdata = w_alu;
                    n_depth = r_depth - DEPTH_W'(1);
                    if (r_op == OP_MOD && r_rd_top == '0) begin
                        w_flag      = 1'b1;
                        w_flag_code = ERR_DIVZERO;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Keep the first error of the expression
    always_comb begin
        n_err = r_err;
        if (r_err == ERR_OK && w_flag) begin
            n_err = w_flag_code;
        end
    end

    // Final beat contents: top after update and closing error check
    always_comb begin
        if (n_depth == '0) begin
            w_answer = '0;
        end else if (w_we) begin
            w_answer = w_wdata;
        end else begin
            w_answer = r_rd_top;
        end
        if (n_err == ERR_OK && n_depth != DEPTH_W'(1)) begin
            w_error = ERR_LEFTOVER;
        end else begin
            w_error = n_err;
        end
    end

    // Stack memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && w_we) begin
            r_stack[w_waddr] <= w_wdata;
        end
        if (i_cmd.cap) begin
            r_rd_top <= r_stack[w_rd_a];
            r_rd_nos <= r_stack[w_rd_b];
        end
    end

    // Hold the accepted token beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind  <= t_kind'(i_kind);
            r_op    <= i_operation;
            r_value <= i_value;
            r_last  <= i_last;
        end
    end

    // Depth and sticky error; restart after the last token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_err   <= ERR_OK;
        end else if (i_cmd.upd) begin
            if (r_last) begin
                r_depth <= '0;
                r_err   <= ERR_OK;
            end else begin
                r_depth <= n_depth;
                r_err   <= n_err;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && r_last) begin
            r_answer <= w_answer;
            r_error  <= w_error;
        end
    end

    assign o_stat.need_div = (r_kind == KIND_BINARY) && (r_op == OP_MOD) && w_ge2 &&
                             (r_rd_top != '0);
    assign o_stat.div_done = w_div_done;
    assign o_stat.last     = r_last;
    assign o_answer        = r_answer;
    assign o_error         = r_error;

endmodule

// ----- design/ppe_ctrl.sv -----
// Controller: token sequencing, divider launch and result valid
module ppe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  ppe_pkg::t_stat i_stat,
    output ppe_pkg::t_cmd  o_cmd
);
    import ppe_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   w_stall;

    // A last token waits while the previous result is still unclaimed
    assign w_stall = i_stat.last && r_out_vld && !i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_stat.need_div) begin
                    n_state = ST_DIV;
                end else if (!w_stall) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (!w_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.cap    = 1'b0;
        o_cmd.upd    = 1'b0;
        o_cmd.div_go = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.div_go = i_stat.need_div;
                o_cmd.upd    = !i_stat.need_div && !w_stall;
            end
            ST_WB: begin
                o_cmd.upd = !w_stall;
            end
            default: begin
            end
        endcase
    end

    // State register and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.upd && i_stat.last) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;

endmodule
